// ----- design/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants for the palette saturate/scale block
// Channel and pixel types, luma weights, reciprocal for division by 100,
// command codes and the RGB565 byte-swapped packing function.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] pixel_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  localparam chan_t SAT_RESET = 8'd150;
  localparam chan_t CHAN_MAX  = 8'd255;

  // ceil(2^23 / 100); exact quotient for every dividend below 65536.
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RECIP_SHIFT = 23;

  // RGB565 with the two bytes swapped for a big-endian panel.
  function automatic pixel_t pack_rgb565_swapped(chan_t r, chan_t g, chan_t b);
    pack_rgb565_swapped = {g[4:2], b[7:3], r[7:3], g[7:5]};
  endfunction

endpackage

`default_nettype wire

// ----- design/pss_ram.sv -----
// ----------------------------------------------------------------------------
// pss_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/palette_saturate_scale_5to4.sv -----
// ----------------------------------------------------------------------------
// palette_saturate_scale_5to4: palette lookup with saturation and 4:5 stretch
// Loads saturation-adjusted colors into a palette RAM and converts indexed
// pixels to byte-swapped RGB565, repeating the last pixel of every group.
// ----------------------------------------------------------------------------
// A word with tuser = 0 loads palette entry tdata[7:0] with the color in
// tdata[31:8]; the color is spread around its luma by the saturation register
// and stored as byte-swapped RGB565. A load goes through accept, luma, spread
// product, then divide/clamp and RAM write, and gives no output. A word with
// tuser = 1 is a pixel index: it is accepted, read through the registered
// palette RAM read port and emitted from S_PIX; the last pixel of each group
// of GROUP_IN goes on to S_DUP to emit its second copy. tlast marks the last
// output of each line of LINE_WIDTH input pixels. The output register lets a
// new word be accepted while a result still waits. Reading a palette entry
// that was never loaded returns an undefined value; there is no clearing pass.
`default_nettype none

module palette_saturate_scale_5to4 #(
  parameter int LINE_WIDTH    = 256,
  parameter int GROUP_IN      = 4,
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,      // saturation_percent
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // color_index[7:0], red_in[15:8], green_in[23:16], blue_in[31:24]
  input  wire logic [31:0]   s_axis_tdata,
  input  wire logic          s_axis_tuser,  // cmd
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output pss_pkg::pixel_t    m_axis_tdata,  // pixel_rgb565[15:0]
  output logic               m_axis_tlast   // line_end
);

  import pss_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(LINE_WIDTH);
  localparam int GW = $clog2(GROUP_IN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LUMA,
    S_PROD,
    S_WRITE,
    S_PIX,
    S_DUP
  } state_t;

  state_t          state;
  chan_t           sat;
  chan_t           idx;
  chan_t           chan [3];
  chan_t           luma;
  logic [15:0]     mag [3];
  logic [2:0]      neg;
  logic            in_range;
  pixel_t          word;
  logic [CW-1:0]   col;
  logic [GW-1:0]   grp;
  logic            dup_last;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic [15:0]     luma_sum;
  logic signed [9:0]  diff [3];
  logic signed [18:0] prod [3];
  logic [32:0]     quot_full [3];
  logic [9:0]      quot [3];
  logic signed [11:0] spread [3];
  chan_t           clamped [3];
  pixel_t          packed_word;
  pixel_t          ram_rdata;
  pixel_t          pix_word;
  logic            ram_we;
  logic            col_last;
  logic            grp_last;
  logic            idx_ok;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = ((state == S_PIX) || (state == S_DUP)) && out_free;
  assign s_axis_tready = (state == S_IDLE);
  assign idx_ok   = ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_DEPTH));

  assign luma_sum = 16'(chan[0]) * LUMA_R + 16'(chan[1]) * LUMA_G + 16'(chan[2]) * LUMA_B;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({2'b00, chan[i]}) - $signed({2'b00, luma});
      prod[i] = diff[i] * $signed({1'b0, sat});
      // Truncation toward zero: divide the magnitude, then restore the sign.
      quot_full[i] = mag[i] * RECIP_100;
      quot[i] = quot_full[i][RECIP_SHIFT +: 10];
      spread[i] = $signed({4'b0000, luma}) +
                  (neg[i] ? -$signed({2'b00, quot[i]}) : $signed({2'b00, quot[i]}));
      if (spread[i] < 0) begin
        clamped[i] = '0;
      end else if (spread[i] > $signed({4'b0000, CHAN_MAX})) begin
        clamped[i] = CHAN_MAX;
      end else begin
        clamped[i] = spread[i][7:0];
      end
    end
    packed_word = pack_rgb565_swapped(clamped[0], clamped[1], clamped[2]);
  end

  assign ram_we   = (state == S_WRITE) && in_range;
  assign pix_word = in_range ? ram_rdata : '0;
  assign col_last = (col == CW'(LINE_WIDTH - 1));
  assign grp_last = (grp == GW'(GROUP_IN - 1));

  pss_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[AW-1:0]),
    .wdata (packed_word),
    .re    (accept && (s_axis_tuser == CMD_PIXEL)),
    .raddr (s_axis_tdata[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sat           <= SAT_RESET;
      col           <= '0;
      grp           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        sat <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= s_axis_tdata[7:0];
            chan[0]  <= s_axis_tdata[15:8];
            chan[1]  <= s_axis_tdata[23:16];
            chan[2]  <= s_axis_tdata[31:24];
            in_range <= idx_ok;
            state    <= (s_axis_tuser == CMD_PIXEL) ? S_PIX : S_LUMA;
          end
        end
        S_LUMA: begin
          luma  <= luma_sum[15:8];
          state <= S_PROD;
        end
        S_PROD: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= prod[i] < 0;
            mag[i] <= prod[i] < 0 ? 16'(-prod[i]) : 16'(prod[i]);
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_PIX: begin
          if (out_free) begin
            m_axis_tdata  <= pix_word;
            word          <= pix_word;
            dup_last      <= col_last;
            col <= col_last ? '0 : col + 1'b1;
            grp <= (col_last || grp_last) ? '0 : grp + 1'b1;
            if (grp_last) begin
              // First copy of a repeated pixel never ends the line.
              m_axis_tlast <= 1'b0;
              state        <= S_DUP;
            end else begin
              m_axis_tlast <= col_last;
              state        <= S_IDLE;
            end
          end
        end
        S_DUP: begin
          if (out_free) begin
            m_axis_tdata  <= word;
            m_axis_tlast  <= dup_last;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Groups restart at every line start.
  a_group_restart: assert property (@(posedge clk) disable iff (rst)
    (col == '0) |-> (grp == '0))
    else $error("group counter not aligned to line start");

  // New output words come only from the pixel path.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_PIX || $past(state) == S_DUP))
    else $error("output word not caused by a pixel");

  // While the second copy is pending, the word on the output is the first copy.
  a_first_copy_no_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUP && m_axis_tvalid) |-> !m_axis_tlast)
    else $error("first copy of repeated pixel carries line end");

  // A load never produces an output word.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && !$past(m_axis_tvalid)) |-> !m_axis_tvalid)
    else $error("palette load produced an output word");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for palette_saturate_scale_5to4
// Loads palette entries at several saturation settings and streams indexed
// pixels under random source gaps and sink stalls. A behavioral predictor
// computes the stored RGB565 words, the 4:5 pixel repeat and the line-end
// flag. Every output word is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pss_pkg::*;

  localparam int LINE_W      = 256;
  localparam int GROUP_N     = 4;
  localparam int DEPTH       = 256;
  localparam int SETTLE      = 10;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct packed {
    pixel_t word;
    logic   line_end;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = CMD_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  pixel_t      m_axis_tdata;
  logic        m_axis_tlast;

  // Predictor state.
  pixel_t      palette_shadow [DEPTH];
  int          loaded_idx [$];
  bit          is_loaded [DEPTH];
  int          column_pos = 0;
  logic [7:0]  sat_shadow = SAT_RESET;
  out_word_t   pending_pixels [$];

  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  out_word_t   head;

  palette_saturate_scale_5to4 #(
    .LINE_WIDTH   (LINE_W),
    .GROUP_IN     (GROUP_N),
    .PALETTE_DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[palette_saturate_scale_5to4] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Moves one channel away from luma by sat percent, truncating toward zero.
  function automatic logic [7:0] spread_channel(input int c, input int luma, input int sat);
    int v;
    v = luma + ((c - luma) * sat) / 100;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic pixel_t saturated_rgb565(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] sat);
    int          luma;
    logic [7:0]  rs, gs, bs;
    logic [15:0] w;
    luma = (int'(r) * int'(LUMA_R) + int'(g) * int'(LUMA_G) + int'(b) * int'(LUMA_B)) >> 8;
    rs = spread_channel(int'(r), luma, int'(sat));
    gs = spread_channel(int'(g), luma, int'(sat));
    bs = spread_channel(int'(b), luma, int'(sat));
    w = {rs[7:3], gs[7:2], bs[7:3]};
    return {w[7:0], w[15:8]};
  endfunction

  function automatic void predict_word(input logic cmd, input logic [7:0] idx,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    pixel_t word;
    bit     last_line, last_group;
    if (cmd == CMD_LOAD) begin
      palette_shadow[idx] = saturated_rgb565(r, g, b, sat_shadow);
      if (!is_loaded[idx]) begin
        is_loaded[idx] = 1'b1;
        loaded_idx.push_back(int'(idx));
      end
    end else begin
      word = palette_shadow[idx];
      last_line = (column_pos == LINE_W - 1);
      last_group = ((column_pos % GROUP_N) == GROUP_N - 1);
      column_pos = last_line ? 0 : column_pos + 1;
      // The repeated pixel carries the line end only on its second copy.
      if (last_group) pending_pixels.push_back('{word, 1'b0});
      pending_pixels.push_back('{word, last_line});
    end
  endfunction

  // Called at a rising edge; returns at the edge where the word is accepted.
  task automatic send_word(input logic cmd, input logic [7:0] idx, input logic [7:0] r = 8'd0,
                           input logic [7:0] g = 8'd0, input logic [7:0] b = 8'd0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {b, g, r, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_word(cmd, idx, r, g, b);
  endtask

  task automatic send_pixel_of_loaded();
    send_word(CMD_PIXEL, 8'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]));
  endtask

  // Waits until every predicted word has come out and loads have settled.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_saturation(input logic [7:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sat_shadow = value;
  endtask

  // Sink side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        head = pending_pixels.pop_front();
        if (m_axis_tdata !== head.word)
          report_mismatch($sformatf("pixel %h, predicted %h", m_axis_tdata, head.word));
        if (m_axis_tlast !== head.line_end)
          report_mismatch($sformatf("line end %b, predicted %b", m_axis_tlast, head.line_end));
      end
    end
  end

  // Extreme colors at the reset saturation, where clamping to both ends occurs.
  task automatic test_reset_saturation();
    send_word(CMD_LOAD, 8'd0,   8'd0,   8'd0,   8'd0);
    send_word(CMD_LOAD, 8'd255, 8'd255, 8'd255, 8'd255);
    send_word(CMD_LOAD, 8'd1,   8'd255, 8'd0,   8'd0);
    send_word(CMD_LOAD, 8'd2,   8'd0,   8'd255, 8'd0);
    send_word(CMD_LOAD, 8'd3,   8'd0,   8'd0,   8'd255);
    foreach (loaded_idx[k]) send_word(CMD_PIXEL, 8'(loaded_idx[k]));
    send_word(CMD_PIXEL, 8'd0);
    send_word(CMD_PIXEL, 8'd255);
    send_word(CMD_PIXEL, 8'd1);
  endtask

  // Grey, maximum spread and identity; also a reload read back at once.
  task automatic test_saturation_extremes();
    write_saturation(8'd0);
    send_word(CMD_LOAD, 8'd4, 8'd200, 8'd30, 8'd90);
    write_saturation(8'd255);
    send_word(CMD_LOAD, 8'd5, 8'd10, 8'd240, 8'd60);
    write_saturation(8'd100);
    send_word(CMD_LOAD, 8'd6, 8'h5a, 8'ha5, 8'h3c);
    send_word(CMD_PIXEL, 8'd4);
    send_word(CMD_PIXEL, 8'd5);
    send_word(CMD_PIXEL, 8'd6);
    send_word(CMD_LOAD, 8'd0, 8'd17, 8'd99, 8'd201);
    send_word(CMD_PIXEL, 8'd0);
    send_word(CMD_PIXEL, 8'd4);
  endtask

  // The sink holds off while the source keeps offering pixels.
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    hold_request = 120;
    repeat (40) send_pixel_of_loaded();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      if ($urandom_range(99) < 14)
        send_word(CMD_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      else
        send_pixel_of_loaded();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_saturation();
    test_saturation_extremes();
    test_random_traffic(0, 0, 350);
    write_saturation(8'd255);
    test_random_traffic(55, 0, 350);
    write_saturation(8'd0);
    test_random_traffic(0, 55, 350);
    write_saturation(8'($urandom_range(1, 254)));
    test_random_traffic(31, 31, 350);
    test_backpressure();
    write_saturation(SAT_RESET);
    test_random_traffic(0, 0, 20);
    wait_drained();
    if (error_count == 0) begin
      $display("[palette_saturate_scale_5to4] OK");
    end else begin
      $display("[palette_saturate_scale_5to4] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
